@@ sv/lbpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink pattern controller package
// Shared types and field widths for the LED blink pattern controller.
// ----------------------------------------------------------------------------
package lbpc_pkg;

    // Fixed widths of the item fields.
    localparam int IDX_W    = 2;
    localparam int FTIME_W  = 16;
    localparam int REP_W    = 16;
    localparam int MASK_W   = 4;
    localparam int OP_W     = 2;
    localparam int NOTIFY_W = 4;

    // Packed widths of the stream data buses, rounded up to whole bytes.
    localparam int IN_FIELDS_W  = IDX_W + 3 * FTIME_W + 1;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 * MASK_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Item kinds carried on the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_ON    = 2'd1,
        OP_OFF   = 2'd2,
        OP_BLINK = 2'd3
    } op_t;

    // Input tdata layout, lowest field last.
    typedef struct packed {
        logic [IN_DATA_W-IN_FIELDS_W-1:0] pad;
        logic                             repeat_forever;
        logic [REP_W-1:0]                 extra_pulses;
        logic [FTIME_W-1:0]               gap_time;
        logic [FTIME_W-1:0]               on_time;
        logic [IDX_W-1:0]                 led_sel;
    } in_item_t;

    // Output tdata layout, lowest field last.
    typedef struct packed {
        logic [OUT_DATA_W-OUT_FIELDS_W-1:0] pad;
        logic [MASK_W-1:0]                  complete_mask;
        logic [MASK_W-1:0]                  busy_mask;
        logic [MASK_W-1:0]                  led_levels;
    } out_item_t;

endpackage
`default_nettype wire

@@ sv/led_blink_pattern_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink pattern controller
// Per-LED blink sequencers driven by tick and command items.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_ stream. s_tuser carries the item kind (tick,
//   steady on, steady off, start blink); s_tdata carries the LED index,
//   the on and off times, the repeat count and the forever flag. Every
//   item yields exactly one result on the m_ stream with the LED levels,
//   the busy flags and the completion pulses seen after that item.
//   The notify_enable register is written through cfg_valid/cfg_data and
//   is always ready; write it only while no item is in flight.
//   An accepted item sits in the input register, then the sequencer update
//   lands in the result register once that register is free. One item per
//   cycle is sustained while the receiver takes every result, since all LED
//   timers are updated together in a single pass of logic.
//   If the receiver stalls, the result register holds and the input
//   register still takes one more item before s_tready drops.
//   Reset turns all LEDs off, stops every timer and clears busy and notify.
// ----------------------------------------------------------------------------
module led_blink_pattern_controller #(
    parameter int NUM_LEDS  = 4,
    parameter int TIME_BITS = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // Input stream.
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // led_sel[1:0], on_time[17:2], gap_time[33:18], extra_pulses[49:34],
    // repeat_forever[50], zero fill above.
    input  wire  [lbpc_pkg::IN_DATA_W-1:0]    s_tdata,
    // op[1:0].
    input  wire  [lbpc_pkg::OP_W-1:0]         s_tuser,
    // Result stream.
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // led_levels[3:0], busy_mask[7:4], complete_mask[11:8], zero fill above.
    output logic [lbpc_pkg::OUT_DATA_W-1:0]   m_tdata,
    // Configuration write channel.
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [lbpc_pkg::NOTIFY_W-1:0]     cfg_data
);

    localparam int EXT_W = NUM_LEDS + lbpc_pkg::MASK_W;

    // Handshake and pipeline control.
    logic                     in_valid_reg;
    lbpc_pkg::op_t            in_op_reg;
    lbpc_pkg::in_item_t       in_item_reg;
    logic                     out_valid_reg;
    lbpc_pkg::out_item_t      out_item_reg;
    lbpc_pkg::out_item_t      out_item_next;
    logic                     advance;
    logic [lbpc_pkg::NOTIFY_W-1:0] notify_reg;

    // Per-LED sequencer state.
    logic [NUM_LEDS-1:0]      lit_reg, lit_next;
    logic [NUM_LEDS-1:0]      blinking_reg, blinking_next;
    logic [NUM_LEDS-1:0]      forever_reg, forever_next;
    logic [NUM_LEDS-1:0]      busy_reg, busy_next;
    logic [TIME_BITS-1:0]     time_left_reg [NUM_LEDS];
    logic [TIME_BITS-1:0]     time_left_next [NUM_LEDS];
    logic [TIME_BITS-1:0]     lit_time_reg [NUM_LEDS];
    logic [TIME_BITS-1:0]     lit_time_next [NUM_LEDS];
    logic [TIME_BITS-1:0]     dark_time_reg [NUM_LEDS];
    logic [TIME_BITS-1:0]     dark_time_next [NUM_LEDS];
    logic [lbpc_pkg::REP_W-1:0] repeats_reg [NUM_LEDS];
    logic [lbpc_pkg::REP_W-1:0] repeats_next [NUM_LEDS];
    logic [NUM_LEDS-1:0]      complete_next;

    logic [TIME_BITS-1:0]     on_clamped;
    logic [TIME_BITS-1:0]     off_clamped;
    logic                     idx_valid;
    logic [EXT_W-1:0]         notify_ext;
    logic [EXT_W-1:0]         lit_ext;
    logic [EXT_W-1:0]         busy_ext;
    logic [EXT_W-1:0]         complete_ext;

    // The result register frees when empty or taken; the input register
    // advances into it and accepts a new item in the same cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_item_reg;
    assign cfg_ready = 1'b1;

    // Notify enable register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notify_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            notify_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= lbpc_pkg::op_t'(s_tuser);
            in_item_reg <= lbpc_pkg::in_item_t'(s_tdata);
        end
    end

    // Blink times are cut to the timer width, a zero becomes one tick.
    always_comb
    begin
        on_clamped  = TIME_BITS'(in_item_reg.on_time);
        off_clamped = TIME_BITS'(in_item_reg.gap_time);
        if (on_clamped == '0)
        begin
            on_clamped = TIME_BITS'(1);
        end
        if (off_clamped == '0)
        begin
            off_clamped = TIME_BITS'(1);
        end
    end

    assign idx_valid  = (32'(in_item_reg.led_sel) < NUM_LEDS);
    assign notify_ext = EXT_W'(notify_reg);

    // Sequencer update: a tick steps every running timer, a command
    // rewrites the addressed LED only.
    always_comb
    begin
        lit_next       = lit_reg;
        blinking_next  = blinking_reg;
        forever_next   = forever_reg;
        busy_next      = busy_reg;
        time_left_next = time_left_reg;
        lit_time_next  = lit_time_reg;
        dark_time_next = dark_time_reg;
        repeats_next   = repeats_reg;
        complete_next  = '0;
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            if (in_op_reg == lbpc_pkg::OP_TICK)
            begin
                if (blinking_reg[i])
                begin
                    if (time_left_reg[i] != '0)
                    begin
                        time_left_next[i] = time_left_reg[i] - TIME_BITS'(1);
                    end
                    if (time_left_next[i] == '0)
                    begin
                        if (!forever_reg[i] && repeats_reg[i] == '0)
                        begin
                            // Finite pattern finished: LED goes dark.
                            lit_next[i]      = 1'b0;
                            blinking_next[i] = 1'b0;
                            forever_next[i]  = 1'b0;
                            repeats_next[i]  = '0;
                            if (notify_ext[i])
                            begin
                                busy_next[i]     = 1'b0;
                                complete_next[i] = 1'b1;
                            end
                        end
                        else if (lit_reg[i])
                        begin
                            lit_next[i]       = 1'b0;
                            time_left_next[i] = dark_time_reg[i];
                        end
                        else
                        begin
                            if (!forever_reg[i])
                            begin
                                repeats_next[i] = repeats_reg[i] - lbpc_pkg::REP_W'(1);
                            end
                            lit_next[i]       = 1'b1;
                            time_left_next[i] = lit_time_reg[i];
                        end
                    end
                end
            end
            else if (idx_valid && (32'(in_item_reg.led_sel) == i))
            begin
                case (in_op_reg)
                    lbpc_pkg::OP_ON, lbpc_pkg::OP_OFF:
                    begin
                        lit_next[i]       = (in_op_reg == lbpc_pkg::OP_ON);
                        blinking_next[i]  = 1'b0;
                        time_left_next[i] = '0;
                        repeats_next[i]   = '0;
                        forever_next[i]   = 1'b0;
                    end
                    lbpc_pkg::OP_BLINK:
                    begin
                        busy_next[i]      = 1'b1;
                        lit_time_next[i]  = on_clamped;
                        dark_time_next[i] = off_clamped;
                        repeats_next[i]   = in_item_reg.extra_pulses;
                        forever_next[i]   = in_item_reg.repeat_forever;
                        lit_next[i]       = 1'b1;
                        blinking_next[i]  = 1'b1;
                        time_left_next[i] = on_clamped;
                    end
                    default:
                    begin
                        lit_next[i] = lit_reg[i];
                    end
                endcase
            end
        end
    end

    // Result fields cover the four lowest LEDs.
    assign lit_ext      = EXT_W'(lit_next);
    assign busy_ext     = EXT_W'(busy_next);
    assign complete_ext = EXT_W'(complete_next);

    always_comb
    begin
        out_item_next               = '0;
        out_item_next.led_levels    = lit_ext[lbpc_pkg::MASK_W-1:0];
        out_item_next.busy_mask     = busy_ext[lbpc_pkg::MASK_W-1:0];
        out_item_next.complete_mask = complete_ext[lbpc_pkg::MASK_W-1:0];
    end

    // Sequencer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg      <= '0;
            blinking_reg <= '0;
            forever_reg  <= '0;
            busy_reg     <= '0;
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                time_left_reg[i] <= '0;
                lit_time_reg[i]  <= '0;
                dark_time_reg[i] <= '0;
                repeats_reg[i]   <= '0;
            end
        end
        else if (advance)
        begin
            lit_reg       <= lit_next;
            blinking_reg  <= blinking_next;
            forever_reg   <= forever_next;
            busy_reg      <= busy_next;
            time_left_reg <= time_left_next;
            lit_time_reg  <= lit_time_next;
            dark_time_reg <= dark_time_next;
            repeats_reg   <= repeats_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // A completing LED is reported dark and no longer busy.
    a_complete_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_item_reg.complete_mask &
            (out_item_reg.led_levels | out_item_reg.busy_mask)) == '0))
        else $error("completion reported on a lit or busy LED");

    // An item moved out of the input register shows up as a result.
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item produced no result");

    // Sequencer invariants per LED.
    for (genvar g = 0; g < NUM_LEDS; g++)
    begin : g_chk
        a_timer_running: assert property (@(posedge clk) disable iff (!rst_n)
            blinking_reg[g] |-> (time_left_reg[g] != '0))
            else $error("blinking LED with an expired timer");

        a_steady_clean: assert property (@(posedge clk) disable iff (!rst_n)
            !blinking_reg[g] |-> (!forever_reg[g] && repeats_reg[g] == '0))
            else $error("steady LED keeps repeat state");
    end

endmodule
`default_nettype wire
